FILE: design/otg_pkg.sv
// Shared types, codes and the packed font table for the OLED text glyph renderer.
// Used by otg_col_step and oled_text_glyph_renderer_unit; depends on nothing.
`default_nettype none
package otg_pkg;

	localparam logic [1:0] KIND_CHAR   = 2'd0;
	localparam logic [1:0] KIND_CURSOR = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_SPAN = 1'b1;

	localparam logic [6:0] LAST_COLUMN   = 7'd127;
	localparam logic [6:0] MAX_START_COL = 7'd121;
	localparam logic [2:0] LAST_PAGE     = 3'd7;
	localparam logic [7:0] CODE_NUL      = 8'd0;
	localparam logic [7:0] CODE_LF       = 8'd10;
	localparam logic [7:0] CODE_CR       = 8'd13;
	localparam logic [7:0] CODE_FIRST    = 8'd32;
	localparam logic [7:0] CODE_DEL      = 8'd127;
	localparam logic [7:0] CODE_MAX      = 8'd191;
	localparam logic [6:0] QMARK_INDEX   = 7'd31;
	localparam logic [7:0] INVERT_MASK   = 8'hFF;

	localparam int GLYPH_COUNT = 95;

	// Five 6-bit columns in bits 0..29, width code (columns - 2) in bits 30..31.
	localparam logic [31:0] GLYPH_ROM [GLYPH_COUNT] = '{
		32'h00000000, 32'h00000df7, 32'h40007007, 32'hd2fd2fd2, 32'hc60dec18,
		32'hf1c8c4e3, 32'he06e59b8, 32'h00000007, 32'h4002185e, 32'h4001e861,
		32'h40014214, 32'h40008708, 32'h00000638, 32'h40008208, 32'h00000618,
		32'h40003330, 32'hde86d85e, 32'h8083f880, 32'he6a69a72, 32'hda965852,
		32'hd0fd2518, 32'hd9965963, 32'hd0a69a9c, 32'hc3159841, 32'hda96595a,
		32'hdea69a46, 32'h000006db, 32'h000006fb, 32'h40011284, 32'h8028a28a,
		32'h40004291, 32'hc7165b41, 32'hefa6d87f, 32'hfe24927e, 32'hfa96597f,
		32'hd286185e, 32'hde86187f, 32'he186597f, 32'hc114517f, 32'hd8a6985e,
		32'hff20823f, 32'h40021fe1, 32'h4003d870, 32'hf128413f, 32'he082083f,
		32'hff0840bf, 32'hff2040bf, 32'hde86185e, 32'hc624927f, 32'hee46985e,
		32'hf624927f, 32'hd2a69952, 32'hc107f041, 32'hdf82081f, 32'hc7620607,
		32'hdf81c81f, 32'hf12842b1, 32'hc3138103, 32'he3965a71, 32'h4002187f,
		32'h40030303, 32'h4003f861, 32'hc4081084, 32'hc4210204, 32'h40004081,
		32'hdcaaaa90, 32'hd892493f, 32'hd48a289c, 32'hff924918, 32'hccaaaa9c,
		32'h8027e200, 32'hdcaaaa84, 32'hf810413f, 32'h00000f40, 32'h00000760,
		32'he250823f, 32'h0000081f, 32'hfc0bc0be, 32'hfc0820be, 32'hdc8a289c,
		32'hc428a2bc, 32'hfc28a284, 32'hc210423e, 32'hd2aaaaa4, 32'h400247c4,
		32'hde82081e, 32'hce42040e, 32'hde81881e, 32'he2508522, 32'hdea28a06,
		32'he6aaaab2, 32'h40021ccc, 32'h00000fc0, 32'h4000cce1, 32'h80108108
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GLYPH,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_code;
		logic [6:0] new_column;
		logic [2:0] new_page;
	} otg_in_t;

	typedef struct packed {
		logic       op;
		logic [2:0] page;
		logic [6:0] column;
		logic [6:0] end_column;
		logic [7:0] data;
		logic       last;
	} otg_out_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [6:0] next_column;
	} step_res_t;

	function automatic logic [31:0] glyph_word(input logic [7:0] code);
		logic [6:0] idx;
		if (code >= CODE_FIRST && code < CODE_DEL)
			idx = 7'(code - CODE_FIRST);
		else
			idx = QMARK_INDEX;
		return GLYPH_ROM[idx];
	endfunction

endpackage
`default_nettype wire

FILE: design/otg_col_step.sv
// Shared column unit: picks one glyph column (or the spacer), applies the invert
// mask and advances the column. Depends on otg_pkg.
`default_nettype none
module otg_col_step (
	input  wire logic [31:0]        glyph,
	input  wire logic [2:0]         idx,
	input  wire logic [2:0]         ncols,
	input  wire logic               invert,
	input  wire logic [6:0]         column,
	output otg_pkg::step_res_t      res
);

	logic [5:0] bits;
	logic [7:0] mask;
	logic       spacer;

	always_comb begin
		unique case (idx)
			3'd0:    bits = glyph[5:0];
			3'd1:    bits = glyph[11:6];
			3'd2:    bits = glyph[17:12];
			3'd3:    bits = glyph[23:18];
			3'd4:    bits = glyph[29:24];
			default: bits = 6'd0;
		endcase
	end

	assign mask   = invert ? otg_pkg::INVERT_MASK : 8'd0;
	// the spacer follows the last glyph column
	assign spacer = (idx == ncols);

	always_comb begin
		res.data        = spacer ? mask : ({2'b00, bits} ^ mask);
		res.last        = spacer;
		res.next_column = column + 7'd1;
	end

endmodule
`default_nettype wire

FILE: design/oled_text_glyph_renderer_unit.sv
// Top level of the OLED text glyph renderer: sequencer, cursor, output register.
// Depends on otg_pkg and otg_col_step.
//
// Usage: each transaction on in_* is a character, a set-cursor or a clear-screen
// command. Results leave on out_* one per cycle while out_ready is high, from a
// single output register; out_item.last marks the final result of a command.
// cfg_* writes invert_text and is always ready.
// Output: a printable character is accepted, then yields one result per column
// byte (3 to 6 column bytes, set by the glyph width code). A newline result is
// loaded in the accept cycle itself. A clear yields one span per page, eight in
// all. Set-cursor and ignored codes yield no result. The column sequencer steps
// the shared column unit.
// in_ready is high only while the sequencer is idle and the output register is
// free or being emptied; a stalled receiver holds the sequencer in place.
// Reset clears the cursor to column 0, page 0, invert_text to 0, and empties the
// output register.
`default_nettype none
module oled_text_glyph_renderer_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire otg_pkg::otg_in_t  in_item,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      otg_pkg::otg_out_t out_item,
	input  wire logic              cfg_valid,
	output      logic              cfg_ready,
	input  wire logic              cfg_data
);

	otg_pkg::state_t   state_q, state_d;
	logic [2:0]        idx_q;
	logic [2:0]        ncols_q;
	logic [31:0]       glyph_q;
	logic [6:0]        col_q;
	logic [3:0]        page_q;
	logic              invert_q;
	otg_pkg::otg_out_t out_q, out_d;
	logic              out_valid_q;
	logic              emit;
	logic              can_load;
	logic              accept;
	logic              is_char, ignored, blocked, newline, printable;
	logic [31:0]       word;
	otg_pkg::step_res_t step;

	assign can_load  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == otg_pkg::ST_IDLE) && can_load;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign is_char   = (in_item.kind == otg_pkg::KIND_CHAR);
	assign ignored   = (in_item.char_code == otg_pkg::CODE_NUL)
		|| (in_item.char_code == otg_pkg::CODE_CR)
		|| (in_item.char_code > otg_pkg::CODE_MAX);
	assign blocked   = page_q[3] || (col_q > otg_pkg::MAX_START_COL);
	assign newline   = is_char && !ignored && !blocked
		&& (in_item.char_code == otg_pkg::CODE_LF);
	assign printable = is_char && !ignored && !blocked
		&& (in_item.char_code != otg_pkg::CODE_LF);
	assign word      = otg_pkg::glyph_word(in_item.char_code);

	otg_col_step u_step (
		.glyph  (glyph_q),
		.idx    (idx_q),
		.ncols  (ncols_q),
		.invert (invert_q),
		.column (col_q),
		.res    (step)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			otg_pkg::ST_IDLE: begin
				if (accept && in_item.kind == otg_pkg::KIND_CLEAR)
					state_d = otg_pkg::ST_CLEAR;
				else if (accept && printable)
					state_d = otg_pkg::ST_GLYPH;
			end
			otg_pkg::ST_GLYPH: begin
				if (can_load && step.last)
					state_d = otg_pkg::ST_IDLE;
			end
			otg_pkg::ST_CLEAR: begin
				if (can_load && idx_q == otg_pkg::LAST_PAGE)
					state_d = otg_pkg::ST_IDLE;
			end
			default: state_d = otg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		emit  = 1'b0;
		out_d = '0;
		unique case (state_q)
			otg_pkg::ST_IDLE: begin
				emit             = accept && newline;
				out_d.op         = otg_pkg::OP_SPAN;
				out_d.page       = page_q[2:0];
				out_d.column     = col_q;
				out_d.end_column = otg_pkg::LAST_COLUMN;
				out_d.data       = 8'd0;
				out_d.last       = 1'b1;
			end
			otg_pkg::ST_GLYPH: begin
				emit             = can_load;
				out_d.op         = otg_pkg::OP_BYTE;
				out_d.page       = page_q[2:0];
				out_d.column     = col_q;
				out_d.end_column = col_q;
				out_d.data       = step.data;
				out_d.last       = step.last;
			end
			otg_pkg::ST_CLEAR: begin
				emit             = can_load;
				out_d.op         = otg_pkg::OP_SPAN;
				out_d.page       = idx_q;
				out_d.column     = 7'd0;
				out_d.end_column = otg_pkg::LAST_COLUMN;
				out_d.data       = 8'd0;
				out_d.last       = (idx_q == otg_pkg::LAST_PAGE);
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= otg_pkg::ST_IDLE;
			idx_q       <= 3'd0;
			col_q       <= 7'd0;
			page_q      <= 4'd0;
			invert_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				invert_q <= cfg_data;
			if (accept) begin
				idx_q <= 3'd0;
				unique case (in_item.kind)
					otg_pkg::KIND_CURSOR: begin
						col_q  <= in_item.new_column;
						page_q <= {1'b0, in_item.new_page};
					end
					otg_pkg::KIND_CLEAR: begin
						col_q  <= 7'd0;
						page_q <= 4'd0;
					end
					default: begin
						// move to the start of the next page
						if (newline) begin
							col_q  <= 7'd0;
							page_q <= page_q + 4'd1;
						end
					end
				endcase
			end else if (state_q == otg_pkg::ST_GLYPH && can_load) begin
				idx_q <= idx_q + 3'd1;
				col_q <= step.next_column;
			end else if (state_q == otg_pkg::ST_CLEAR && can_load) begin
				idx_q <= idx_q + 3'd1;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			glyph_q <= word;
			ncols_q <= 3'd2 + {1'b0, word[31:30]};
		end
		if (emit)
			out_q <= out_d;
	end

endmodule
`default_nettype wire
